// File: rtl/scbe_pkg.sv
// ----------------------------------------------------------------------------
// Solid color block encoder package
// Shared item types, stage records and constants of the solid color encoder.
// ----------------------------------------------------------------------------
package scbe_pkg;

   typedef struct packed {
      logic [7:0] blue_level;
      logic [7:0] green_level;
      logic [7:0] red_level;
   } req_item_type;

   typedef struct packed {
      logic [15:0] first_endpoint;
      logic [15:0] second_endpoint;
      logic [1:0]  selector;
      logic [63:0] block_word;
   } rsp_item_type;

   typedef struct packed {
      logic [5:0]  level;
      logic [11:0] scaled;
      logic        den7;
   } chan_type;

   typedef struct packed {
      logic     valid;
      chan_type red;
      chan_type green;
      chan_type blue;
   } quant_stage_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] c1;
      logic [15:0] c2;
      logic [4:0]  sum;
      logic [1:0]  count;
   } score_stage_type;

   localparam logic [4:0]  SCORE_FULL   = 5'd12;
   localparam logic [4:0]  SCORE_LOW    = 5'd2;
   localparam logic [4:0]  SCORE_MID    = 5'd6;
   localparam logic [4:0]  SCORE_HIGH   = 5'd10;
   localparam logic [15:0] ENDPOINT_MAX = 16'hFFFF;

   localparam int RECIP7       = 4682;
   localparam int RECIP7_SHIFT = 15;
   localparam int RECIP3       = 11;
   localparam int RECIP3_SHIFT = 5;

   localparam logic [1:0] SEL_FIRST      = 2'd0;
   localparam logic [1:0] SEL_SECOND     = 2'd1;
   localparam logic [1:0] SEL_NEAR_FIRST = 2'd2;
   localparam logic [1:0] SEL_NEAR_SEC   = 2'd3;

   localparam logic CSR_MODE_INDEX = 1'b0;

endpackage

// File: rtl/solid_color_block_encode.sv
// ----------------------------------------------------------------------------
// Solid color block encoder
// Turns one 8-bit blue, green, red color into a 64-bit 5:6:5 color block.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle while busy is low and
// returns its results in the order of the items, through three register
// stages (quantize, score, pack). busy is high only during reset and in the
// first cycle after it. A result is shown on rsp_item for one cycle with
// rsp_strobe high and cannot be held off. The deduced alpha mode register
// lies at byte address 0 of the csr port and should be written only while
// no item is in flight.
module solid_color_block_encode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  scbe_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output scbe_pkg::rsp_item_type rsp_item,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import scbe_pkg::*;

   logic            busy_ff;
   logic            busy_in;
   logic            mode_ff;
   logic            mode_in;
   logic            csr_write;
   logic            req_accept;
   quant_stage_type quant_stage;
   score_stage_type score_stage;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_accept = start && !busy_ff;
   assign busy_in    = reset;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && csr_paddr[2] == CSR_MODE_INDEX) begin
         mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_MODE_INDEX) ? {31'd0, mode_ff} : 32'd0;
   assign busy       = busy_ff;

   scbe_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_item   (req_item),
      .out_stage (quant_stage)
   );

   scbe_score u_score (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (quant_stage),
      .out_stage (score_stage)
   );

   scbe_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .in_stage   (score_stage),
      .out_strobe (rsp_strobe),
      .out_item   (rsp_item)
   );

endmodule

// File: rtl/scbe_quant.sv
// ----------------------------------------------------------------------------
// Solid color block encoder, quantize stage
// Truncates each channel to its 5:6:5 level and scales the residual by 12.
// ----------------------------------------------------------------------------
module scbe_quant (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  scbe_pkg::req_item_type in_item,
   output scbe_pkg::quant_stage_type out_stage
);
   import scbe_pkg::*;

   quant_stage_type s1_ff;
   quant_stage_type s1_in;

   function automatic chan_type quant5(logic [7:0] x);
      logic [7:0] trimmed;
      logic [4:0] q;
      logic [7:0] expanded;
      logic [7:0] diff;
      chan_type   c;
      trimmed  = x - (x >> 5);
      q        = trimmed[7:3];
      expanded = {q, 3'b000} + 8'(q >> 2);
      diff     = x - expanded;
      c.level  = {1'b0, q};
      c.scaled = {1'b0, diff, 3'b000} + {2'b00, diff, 2'b00};
      c.den7   = q[0] & q[4];
      return c;
   endfunction

   function automatic chan_type quant6(logic [7:0] x);
      logic [7:0] trimmed;
      logic [5:0] q;
      logic [7:0] expanded;
      logic [7:0] diff;
      chan_type   c;
      trimmed  = x - (x >> 6);
      q        = trimmed[7:2];
      expanded = {q, 2'b00} + 8'(q >> 4);
      diff     = x - expanded;
      c.level  = q;
      c.scaled = {1'b0, diff, 3'b000} + {2'b00, diff, 2'b00};
      c.den7   = 1'b0;
      return c;
   endfunction

   always_comb begin
      s1_in.valid = in_valid;
      s1_in.red   = quant5(in_item.red_level);
      s1_in.green = quant6(in_item.green_level);
      s1_in.blue  = quant5(in_item.blue_level);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   assign out_stage = s1_ff;

endmodule

// File: rtl/scbe_score.sv
// ----------------------------------------------------------------------------
// Solid color block encoder, score stage
// Forms channel scores, picks endpoint levels, sums the votes and counts split channels.
// ----------------------------------------------------------------------------
module scbe_score (
   input  logic                      clock,
   input  logic                      reset,
   input  scbe_pkg::quant_stage_type in_stage,
   output scbe_pkg::score_stage_type out_stage
);
   import scbe_pkg::*;

   typedef struct packed {
      logic [6:0] first;
      logic [6:0] second;
      logic       differ;
      logic [3:0] vote;
   } pick_type;

   score_stage_type s2_ff;
   score_stage_type s2_in;
   pick_type        red_pick;
   pick_type        green_pick;
   pick_type        blue_pick;

   function automatic pick_type eval_chan(chan_type ch);
      logic [24:0] recip;
      logic [8:0]  score;
      logic [6:0]  lvl;
      logic [6:0]  inc;
      pick_type    p;
      recip = 25'(ch.scaled) * 25'(RECIP7);
      score = ch.den7 ? 9'(recip >> RECIP7_SHIFT) : 9'(ch.scaled >> 3);
      lvl   = {1'b0, ch.level};
      inc   = lvl + 7'd1;
      p.differ = 1'b1;
      if (score < 9'(SCORE_LOW)) begin
         p.first  = lvl;
         p.second = lvl;
         p.differ = 1'b0;
      end else if (score < 9'(SCORE_MID)) begin
         p.first  = lvl;
         p.second = inc;
      end else if (score < 9'(SCORE_HIGH)) begin
         p.first  = inc;
         p.second = lvl;
      end else begin
         p.first  = inc;
         p.second = inc;
         p.differ = 1'b0;
      end
      if (!p.differ) begin
         p.vote = 4'd0;
      end else if (score < 9'(SCORE_MID)) begin
         p.vote = score[3:0];
      end else begin
         p.vote = 4'(SCORE_FULL - {1'b0, score[3:0]});
      end
      return p;
   endfunction

   always_comb begin
      red_pick    = eval_chan(in_stage.red);
      green_pick  = eval_chan(in_stage.green);
      blue_pick   = eval_chan(in_stage.blue);
      s2_in.valid = in_stage.valid;
      s2_in.c1    = 16'(red_pick.first) | (16'(green_pick.first) << 5)
                    | (16'(blue_pick.first) << 11);
      s2_in.c2    = 16'(red_pick.second) | (16'(green_pick.second) << 5)
                    | (16'(blue_pick.second) << 11);
      s2_in.sum   = 5'(red_pick.vote) + 5'(green_pick.vote) + 5'(blue_pick.vote);
      s2_in.count = 2'(red_pick.differ) + 2'(green_pick.differ)
                    + 2'(blue_pick.differ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else begin
         s2_ff <= s2_in;
      end
   end

   assign out_stage = s2_ff;

endmodule

// File: rtl/scbe_pack.sv
// ----------------------------------------------------------------------------
// Solid color block encoder, pack stage
// Averages the votes, separates and orders the endpoints, picks the selector
// and registers the finished block.
// ----------------------------------------------------------------------------
module scbe_pack (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mode,
   input  scbe_pkg::score_stage_type in_stage,
   output logic                      out_strobe,
   output scbe_pkg::rsp_item_type    out_item
);
   import scbe_pkg::*;

   localparam logic [4:0] AVG_SPLIT_LO = 5'd5;
   localparam logic [4:0] AVG_SPLIT_HI = 5'd6;

   logic         strobe_ff;
   logic         strobe_in;
   rsp_item_type item_ff;
   rsp_item_type item_in;

   logic [5:0]  plus1;
   logic [9:0]  third;
   logic [4:0]  avg;
   logic        special;
   logic [15:0] c1n;
   logic [15:0] c2n;
   logic [4:0]  adj;
   logic [15:0] hi;
   logic [15:0] lo;
   logic [4:0]  fin;
   logic [1:0]  sel;

   always_comb begin
      plus1 = {1'b0, in_stage.sum} + 6'd1;
      third = 10'(plus1) * 10'(RECIP3);
      case (in_stage.count)
         2'd0: avg = 5'd0;
         2'd1: avg = in_stage.sum;
         2'd2: avg = plus1[5:1];
         2'd3: avg = 5'(third >> RECIP3_SHIFT);
         default: avg = 5'd0;
      endcase

      special = mode && (avg == AVG_SPLIT_LO || avg == AVG_SPLIT_HI
                         || in_stage.count != 2'd0);

      c1n = in_stage.c1;
      c2n = in_stage.c2;
      adj = avg;
      if (in_stage.count != 2'd0 && !special) begin
         if (in_stage.c2 == ENDPOINT_MAX) begin
            adj = SCORE_FULL;
            c1n = in_stage.c1 - 16'd1;
         end else begin
            adj = 5'd0;
            c2n = in_stage.c2 + 16'd1;
         end
      end

      if (c2n >= c1n) begin
         hi  = c2n;
         lo  = c1n;
         fin = SCORE_FULL - adj;
      end else begin
         hi  = c1n;
         lo  = c2n;
         fin = adj;
      end

      if (special) begin
         sel = SEL_NEAR_FIRST;
      end else if (fin < SCORE_LOW) begin
         sel = SEL_FIRST;
      end else if (fin < SCORE_MID) begin
         sel = SEL_NEAR_FIRST;
      end else if (fin < SCORE_HIGH) begin
         sel = SEL_NEAR_SEC;
      end else begin
         sel = SEL_SECOND;
      end

      strobe_in               = in_stage.valid;
      item_in.first_endpoint  = hi;
      item_in.second_endpoint = lo;
      item_in.selector        = sel;
      item_in.block_word      = {{16{sel}}, lo, hi};
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign out_strobe = strobe_ff;
   assign out_item   = item_ff;

endmodule

// File: rtl/scbe_checker.sv
// ----------------------------------------------------------------------------
// Solid color block encoder checker
// Port-level checks of latency, endpoint order and block layout, bound to the top level.
// ----------------------------------------------------------------------------
module scbe_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input scbe_pkg::rsp_item_type rsp_item
);
   import scbe_pkg::*;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("Accepted item produced no result after three cycles.");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 3))
      else $error("Result appeared without an accepted item.");

   a_order : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.first_endpoint >= rsp_item.second_endpoint)
      else $error("First endpoint is smaller than the second.");

   a_layout : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.block_word[15:0] == rsp_item.first_endpoint
                      && rsp_item.block_word[31:16] == rsp_item.second_endpoint
                      && rsp_item.block_word[33:32] == rsp_item.selector
                      && rsp_item.block_word[63:62] == rsp_item.selector))
      else $error("Block word does not match the endpoints and selector.");

endmodule

bind solid_color_block_encode scbe_checker u_scbe_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
